>>> rtl/tpe_pkg.sv
// Shared types, constants and helpers for the tree path edge extreme block.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none
package tpe_pkg;

   localparam int NODE_W   = 11;
   localparam int WEIGHT_W = 31;

   localparam logic signed [WEIGHT_W-1:0] SENT_FOR_MAX = -31'sd1000000000;
   localparam logic signed [WEIGHT_W-1:0] SENT_FOR_MIN = 31'sd1000000000;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_I_RDDEP,
      OP_I_BASE,
      OP_I_RD,
      OP_I_WR,
      OP_Q_RDU,
      OP_Q_RDV,
      OP_Q_ORDER,
      OP_L_RD,
      OP_L_DEP,
      OP_L_STEP,
      OP_CHK,
      OP_M_RDU,
      OP_M_RDV,
      OP_M_STEP,
      OP_F_RDU,
      OP_F_RDV,
      OP_F_DONE
   } op_type;

   typedef struct packed {
      logic mode;
      logic bad_insert;
      logic u_eq_v;
      logic lvl_zero;
      logic lvl_ins_last;
      logic rsp_busy;
   } status_type;

   function automatic logic signed [WEIGHT_W-1:0] sentinel(input logic is_max);
      return is_max ? SENT_FOR_MAX : SENT_FOR_MIN;
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] pick(
      input logic                       is_max,
      input logic signed [WEIGHT_W-1:0] a,
      input logic signed [WEIGHT_W-1:0] b
   );
      if (is_max) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

endpackage
`default_nettype wire

>>> rtl/tpe_req_if.sv
// Request channel: valid/ready handshake with one insert or query beat.
// Depends on tpe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface tpe_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     mode;
   logic [tpe_pkg::NODE_W-1:0]               node_a;
   logic [tpe_pkg::NODE_W-1:0]               node_b;
   logic signed [tpe_pkg::WEIGHT_W-1:0]      weight;

   modport source (output valid, mode, node_a, node_b, weight, input ready);
   modport sink (input valid, mode, node_a, node_b, weight, output ready);
endinterface
`default_nettype wire

>>> rtl/tpe_rsp_if.sv
// Response channel: valid/ready handshake carrying one path extreme beat.
// Depends on tpe_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none
interface tpe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tpe_pkg::WEIGHT_W-1:0] path_extreme;

   modport source (output valid, path_extreme, input ready);
   modport sink (input valid, path_extreme, output ready);
endinterface
`default_nettype wire

>>> rtl/tree_path_edge_extreme_core.sv
// Top level of the tree path edge extreme block: controller plus table datapath.
// Depends on tpe_pkg, tpe_req_if, tpe_rsp_if, tpe_ctrl and tpe_datapath.
//
// The block keeps binary-lifting tables of a rooted, edge-weighted tree and answers
// path maximum or minimum queries. Nodes must be inserted parent-first, and a query
// may only name inserted nodes or node 0; no table is cleared after reset. An insert
// reads the parent's depth, writes level 0, then reads and writes each higher level;
// a query orders the nodes by depth, lifts the deeper one, then lifts both together.
// Every step is one read of a single-port table whose data is registered before use.
// A new beat is taken while the previous result still waits on the response port.
`timescale 1ns / 1ps
`default_nettype none
module tree_path_edge_extreme_core #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input wire           clock,
   input wire           reset,
   tpe_req_if.sink      req_ch,
   tpe_rsp_if.source    rsp_ch,
   input wire           csr_we,
   input wire           csr_wdata
);
   tpe_pkg::op_type     op;
   tpe_pkg::status_type status;

   tpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .op        (op)
   );

   tpe_datapath #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_mode   (req_ch.mode),
      .in_node_a (req_ch.node_a),
      .in_node_b (req_ch.node_b),
      .in_weight (req_ch.weight),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.path_extreme),
      .rsp_ready (rsp_ch.ready)
   );
endmodule
`default_nettype wire

>>> rtl/tpe_datapath.sv
// Datapath: depth, ancestor and jump tables, walk registers and response register.
// Depends on tpe_pkg; driven one operation per cycle by tpe_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module tpe_datapath #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire tpe_pkg::op_type                  op,
   output tpe_pkg::status_type                   status,
   input  wire                                   csr_we,
   input  wire                                   csr_wdata,
   input  wire                                   in_mode,
   input  wire [tpe_pkg::NODE_W-1:0]             in_node_a,
   input  wire [tpe_pkg::NODE_W-1:0]             in_node_b,
   input  wire signed [tpe_pkg::WEIGHT_W-1:0]    in_weight,
   output logic                                  rsp_valid,
   output logic signed [tpe_pkg::WEIGHT_W-1:0]   rsp_data,
   input  wire                                   rsp_ready
);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int LW = $clog2(LEVELS + 1);
   localparam int AW = LW + NW;
   localparam int WW = tpe_pkg::WEIGHT_W;

   logic [NW-1:0]        dep_mem [2**NW];
   logic [NW-1:0]        anc_mem [2**AW];
   logic signed [WW-1:0] jmp_mem [2**AW];

   logic                 is_max_ff;
   logic [NW-1:0]        u_ff, u_in, v_ff, v_in, t_ff, t_in;
   logic [NW-1:0]        du_ff, du_in, dv_ff, dv_in;
   logic [LW-1:0]        lvl_ff, lvl_in;
   logic signed [WW-1:0] acc_ff, acc_in, jv_ff, jv_in, w_ff, w_in;
   logic                 mode_ff, mode_in, bad_ff, bad_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [WW-1:0] rsp_data_ff, rsp_data_in;

   logic [NW-1:0]        dep_q, anc_q;
   logic signed [WW-1:0] jmp_q;
   logic                 dep_zero_ff, tab_zero_ff;
   logic [NW-1:0]        dep_val, anc_val;
   logic signed [WW-1:0] jmp_val, sent;

   logic [NW-1:0]        dep_rd_node, tab_rd_node;
   logic [LW-1:0]        tab_rd_lvl, tab_wr_lvl;
   logic                 dep_we, tab_we;
   logic [NW-1:0]        dep_wdata, anc_wdata;
   logic signed [WW-1:0] jmp_wdata, pick_a, pick_b;
   logic [31:0]          a_ext, b_ext;
   logic [NW-1:0]        a_clamp, b_clamp;
   logic                 busy;

   assign sent    = tpe_pkg::sentinel(is_max_ff);
   assign dep_val = dep_zero_ff ? '0 : dep_q;
   assign anc_val = tab_zero_ff ? '0 : anc_q;
   assign jmp_val = tab_zero_ff ? sent : jmp_q;
   assign busy    = rsp_valid_ff && !rsp_ready;

   assign a_ext   = 32'(in_node_a);
   assign b_ext   = 32'(in_node_b);
   assign a_clamp = (a_ext > 32'(MAX_NODES)) ? '0 : a_ext[NW-1:0];
   assign b_clamp = (b_ext > 32'(MAX_NODES)) ? '0 : b_ext[NW-1:0];

   assign pick_a = tpe_pkg::pick(is_max_ff, acc_ff, jv_ff);
   assign pick_b = tpe_pkg::pick(is_max_ff, pick_a, jmp_val);

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      t_in = t_ff;
      du_in = du_ff;
      dv_in = dv_ff;
      lvl_in = lvl_ff;
      acc_in = acc_ff;
      jv_in = jv_ff;
      w_in = w_ff;
      mode_in = mode_ff;
      bad_in = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      dep_rd_node = u_ff;
      tab_rd_node = u_ff;
      tab_rd_lvl = lvl_ff;
      tab_wr_lvl = lvl_ff + LW'(1);
      dep_we = 1'b0;
      tab_we = 1'b0;
      dep_wdata = (dep_val >= NW'(MAX_NODES)) ? NW'(MAX_NODES) : dep_val + NW'(1);
      anc_wdata = anc_val;
      jmp_wdata = tpe_pkg::pick(is_max_ff, jv_ff, jmp_val);
      unique case (op)
         tpe_pkg::OP_NOP: begin
         end
         tpe_pkg::OP_LOAD: begin
            u_in = a_clamp;
            v_in = b_clamp;
            t_in = b_clamp;
            w_in = in_weight;
            mode_in = in_mode;
            bad_in = (in_node_a == '0) || (a_ext > 32'(MAX_NODES))
               || (b_ext > 32'(MAX_NODES));
         end
         tpe_pkg::OP_I_RDDEP: begin
            dep_rd_node = t_ff;
         end
         tpe_pkg::OP_I_BASE: begin
            dep_we = 1'b1;
            tab_we = 1'b1;
            tab_wr_lvl = '0;
            anc_wdata = t_ff;
            jmp_wdata = (t_ff == '0) ? sent : w_ff;
            jv_in = jmp_wdata;
            lvl_in = '0;
         end
         tpe_pkg::OP_I_RD: begin
            tab_rd_node = t_ff;
         end
         tpe_pkg::OP_I_WR: begin
            tab_we = 1'b1;
            jv_in = jmp_wdata;
            t_in = anc_val;
            lvl_in = lvl_ff + LW'(1);
         end
         tpe_pkg::OP_Q_RDU: begin
            dep_rd_node = u_ff;
         end
         tpe_pkg::OP_Q_RDV: begin
            du_in = dep_val;
            dep_rd_node = v_ff;
         end
         tpe_pkg::OP_Q_ORDER: begin
            acc_in = sent;
            lvl_in = LW'(LEVELS);
            if (du_ff < dep_val) begin
               u_in = v_ff;
               v_in = u_ff;
               dv_in = du_ff;
            end else begin
               dv_in = dep_val;
            end
         end
         tpe_pkg::OP_L_RD: begin
            tab_rd_node = u_ff;
         end
         tpe_pkg::OP_L_DEP: begin
            t_in = anc_val;
            jv_in = jmp_val;
            dep_rd_node = anc_val;
         end
         tpe_pkg::OP_L_STEP: begin
            if (dep_val >= dv_ff) begin
               acc_in = pick_a;
               u_in = t_ff;
            end
            lvl_in = lvl_ff - LW'(1);
         end
         tpe_pkg::OP_CHK: begin
            if (u_ff == v_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = acc_ff;
            end else begin
               lvl_in = LW'(LEVELS);
            end
         end
         tpe_pkg::OP_M_RDU: begin
            tab_rd_node = u_ff;
         end
         tpe_pkg::OP_M_RDV: begin
            t_in = anc_val;
            jv_in = jmp_val;
            tab_rd_node = v_ff;
         end
         tpe_pkg::OP_M_STEP: begin
            if (t_ff != anc_val) begin
               acc_in = pick_b;
               u_in = t_ff;
               v_in = anc_val;
            end
            lvl_in = lvl_ff - LW'(1);
         end
         tpe_pkg::OP_F_RDU: begin
            tab_rd_lvl = '0;
            tab_rd_node = u_ff;
         end
         tpe_pkg::OP_F_RDV: begin
            acc_in = tpe_pkg::pick(is_max_ff, acc_ff, jmp_val);
            tab_rd_lvl = '0;
            tab_rd_node = v_ff;
         end
         tpe_pkg::OP_F_DONE: begin
            tab_rd_lvl = '0;
            tab_rd_node = v_ff;
            if (!busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = tpe_pkg::pick(is_max_ff, acc_ff, jmp_val);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[u_ff] <= dep_wdata;
      end
      if (tab_we) begin
         anc_mem[{tab_wr_lvl, u_ff}] <= anc_wdata;
         jmp_mem[{tab_wr_lvl, u_ff}] <= jmp_wdata;
      end
      dep_q <= dep_mem[dep_rd_node];
      anc_q <= anc_mem[{tab_rd_lvl, tab_rd_node}];
      jmp_q <= jmp_mem[{tab_rd_lvl, tab_rd_node}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_max_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         mode_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            is_max_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
         mode_ff <= mode_in;
         bad_ff <= bad_in;
      end
      dep_zero_ff <= (dep_rd_node == '0);
      tab_zero_ff <= (tab_rd_node == '0);
      u_ff <= u_in;
      v_ff <= v_in;
      t_ff <= t_in;
      du_ff <= du_in;
      dv_ff <= dv_in;
      lvl_ff <= lvl_in;
      acc_ff <= acc_in;
      jv_ff <= jv_in;
      w_ff <= w_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.mode         = mode_ff;
   assign status.bad_insert   = bad_ff;
   assign status.u_eq_v       = (u_ff == v_ff);
   assign status.lvl_zero     = (lvl_ff == '0);
   assign status.lvl_ins_last = (lvl_ff == LW'(LEVELS - 1));
   assign status.rsp_busy     = busy;
endmodule
`default_nettype wire

>>> rtl/tpe_ctrl.sv
// Controller: sequences insert and query walks over the table datapath.
// Depends on tpe_pkg for the operation codes and status bundle.
`timescale 1ns / 1ps
`default_nettype none
module tpe_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire tpe_pkg::status_type status,
   output tpe_pkg::op_type          op
);
   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_I_DEP, S_I_BASE, S_I_RD, S_I_WR,
      S_Q_RDU, S_Q_RDV, S_Q_ORD, S_L_RD, S_L_DEP, S_L_STEP, S_CHK,
      S_M_RDU, S_M_RDV, S_M_STEP, S_F_RDU, S_F_RDV, S_F_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      op = tpe_pkg::OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = tpe_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (status.mode == tpe_pkg::MODE_QUERY) begin
               state_in = S_Q_RDU;
            end else if (status.bad_insert) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_I_DEP;
            end
         end
         S_I_DEP: begin
            op = tpe_pkg::OP_I_RDDEP;
            state_in = S_I_BASE;
         end
         S_I_BASE: begin
            op = tpe_pkg::OP_I_BASE;
            state_in = S_I_RD;
         end
         S_I_RD: begin
            op = tpe_pkg::OP_I_RD;
            state_in = S_I_WR;
         end
         S_I_WR: begin
            op = tpe_pkg::OP_I_WR;
            state_in = status.lvl_ins_last ? S_IDLE : S_I_RD;
         end
         S_Q_RDU: begin
            op = tpe_pkg::OP_Q_RDU;
            state_in = S_Q_RDV;
         end
         S_Q_RDV: begin
            op = tpe_pkg::OP_Q_RDV;
            state_in = S_Q_ORD;
         end
         S_Q_ORD: begin
            op = tpe_pkg::OP_Q_ORDER;
            state_in = S_L_RD;
         end
         S_L_RD: begin
            op = tpe_pkg::OP_L_RD;
            state_in = S_L_DEP;
         end
         S_L_DEP: begin
            op = tpe_pkg::OP_L_DEP;
            state_in = S_L_STEP;
         end
         S_L_STEP: begin
            op = tpe_pkg::OP_L_STEP;
            state_in = status.lvl_zero ? S_CHK : S_L_RD;
         end
         S_CHK: begin
            if (!status.rsp_busy) begin
               op = tpe_pkg::OP_CHK;
               state_in = status.u_eq_v ? S_IDLE : S_M_RDU;
            end
         end
         S_M_RDU: begin
            op = tpe_pkg::OP_M_RDU;
            state_in = S_M_RDV;
         end
         S_M_RDV: begin
            op = tpe_pkg::OP_M_RDV;
            state_in = S_M_STEP;
         end
         S_M_STEP: begin
            op = tpe_pkg::OP_M_STEP;
            state_in = status.lvl_zero ? S_F_RDU : S_M_RDU;
         end
         S_F_RDU: begin
            op = tpe_pkg::OP_F_RDU;
            state_in = S_F_RDV;
         end
         S_F_RDV: begin
            op = tpe_pkg::OP_F_RDV;
            state_in = S_F_DONE;
         end
         S_F_DONE: begin
            op = tpe_pkg::OP_F_DONE;
            if (!status.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire
